>>> rtl/brb_pkg.sv
// Package: shared types, constants and helper functions of the banked ring buffer pointer unit.
package brb_pkg;

  localparam int MAX_BANKS_DEF = 8;
  localparam int CHUNK_MAX_DEF = 255;

  localparam logic [14:0] WIN_BASE  = 15'h4000;
  localparam logic [14:0] BANK_SIZE = 15'h4000;
  localparam logic [14:0] OFF_MAX   = 15'h3FFF;
  localparam logic [15:0] FILL_MAX  = 16'hFFFF;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic CFG_NUM_BANKS  = 1'b0;
  localparam logic CFG_BANK_TABLE = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  bank_select;
    logic [14:0] address;
    logic [7:0]  seg_len;
    logic [15:0] fill_level;
    logic        last;
  } out_item_t;

  // Next bank going forward around the ring of n banks.
  function automatic logic [2:0] next_bank(input logic [2:0] b, input logic [3:0] n);
    logic [3:0] inc;
    inc = {1'b0, b} + 4'd1;
    return (inc >= n) ? 3'd0 : inc[2:0];
  endfunction

  // Bytes held in the buffer for the given pointers, saturated at FILL_MAX.
  function automatic logic [15:0] fill_calc(input logic [3:0]  n,
                                            input logic [2:0]  wb,
                                            input logic [13:0] wo,
                                            input logic [2:0]  rb,
                                            input logic [13:0] ro);
    logic [3:0]  lap_banks;
    logic [17:0] sum;
    logic [15:0] res;
    if (n == 4'd0) begin
      res = 16'd0;
    end else if (wb == rb && ro <= wo) begin
      res = {2'b00, wo - ro};
    end else begin
      // Banks from the reader's bank forward to the writer's; equal banks mean a full lap.
      lap_banks = {1'b0, wb} + ((wb > rb) ? 4'd0 : n) - {1'b0, rb};
      sum  = {lap_banks, 14'd0} - {4'd0, ro} + {4'd0, wo};
      res  = (sum[17:16] != 2'b00) ? FILL_MAX : sum[15:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/banked_ring_buffer_pointers.sv
// Banked ring buffer pointer unit: top level with pointer state and result registers.
//
// Usage: configuration is written through cfg_wr_en/cfg_index/cfg_data while the
// block is idle. Index 0 sets the number of banks (values above MAX_BANKS act as
// MAX_BANKS) and returns all pointers to the start; index 1 loads the eight
// bank-select bytes. Items enter on in_valid/in_stall: a write offer grants room
// up to the bank end or the reader, a read returns one or two segments split at
// the bank end, and a status query returns the fill level.
// The first result of an item enters the output register in the cycle after
// the item is accepted. Items are taken at one item per cycle while in_stall is low;
// a read that crosses a bank end is returned as two output items, the second
// segment waiting in a holding register while in_stall is high. When the
// receiver raises out_stall, the output register holds its item and in_stall
// follows until space frees up.
// Reset clears the pointers, both configuration registers and the output side.
module banked_ring_buffer_pointers #(
  parameter int MAX_BANKS = brb_pkg::MAX_BANKS_DEF,
  parameter int CHUNK_MAX = brb_pkg::CHUNK_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  brb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output brb_pkg::out_item_t out_item
);
  import brb_pkg::*;

  localparam logic [3:0] MaxBanksW = 4'(MAX_BANKS);
  localparam logic [7:0] ChunkMaxW = 8'(CHUNK_MAX);

  logic [3:0]  num_banks_r;
  logic [63:0] bank_table_r;
  logic [2:0]  wb_r, wb_nxt, rb_r, rb_nxt;
  logic [13:0] wo_r, wo_nxt, ro_r, ro_nxt;

  logic      out_valid_r, out_valid_nxt, pend_valid_r, pend_valid_nxt;
  out_item_t out_item_r, out_item_nxt, pend_item_r, pend_item_nxt;

  logic      accept, out_free;
  out_item_t res0, res1;
  logic      two_res;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = pend_valid_r || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Item processing: next pointers and the result items.
  always_comb begin
    logic [3:0]  n;
    logic [2:0]  wnext, rnext;
    logic [14:0] limit, room, wsum, rsum, first;
    logic [7:0]  grant, first8;
    logic        split;
    n      = (num_banks_r > MaxBanksW) ? MaxBanksW : num_banks_r;
    wnext  = next_bank(wb_r, n);
    rnext  = next_bank(rb_r, n);
    wb_nxt = wb_r;
    wo_nxt = wo_r;
    rb_nxt = rb_r;
    ro_nxt = ro_r;
    two_res = 1'b0;

    // Write grant: stop one short of the reader so a full buffer never reads as empty.
    if (wb_r == rb_r && wo_r < ro_r) begin
      limit = {1'b0, ro_r} - 15'd1;
    end else if (wnext == rb_r && ro_r == 14'd0) begin
      limit = OFF_MAX;
    end else begin
      limit = BANK_SIZE;
    end
    room  = (limit > {1'b0, wo_r}) ? limit - {1'b0, wo_r} : 15'd0;
    grant = (in_item.length < ChunkMaxW) ? in_item.length : ChunkMaxW;
    if ({7'd0, grant} > room) begin
      grant = room[7:0];
    end
    wsum = {1'b0, wo_r} + {7'd0, grant};

    rsum   = {1'b0, ro_r} + {7'd0, in_item.length};
    split  = rsum > BANK_SIZE;
    first  = BANK_SIZE - {1'b0, ro_r};
    first8 = first[7:0];

    res0 = '{bank_select: 8'd0, address: WIN_BASE, seg_len: 8'd0,
             fill_level: 16'd0, last: 1'b1};
    res1 = res0;

    unique case (in_item.cmd)
      CMD_WRITE: begin
        res0.address = WIN_BASE | {1'b0, wo_r};
        if (n != 4'd0) begin
          res0.bank_select = bank_table_r[{wb_r, 3'b000} +: 8];
          res0.seg_len     = grant;
          if (wsum[14]) begin
            wo_nxt = 14'd0;
            wb_nxt = wnext;
          end else begin
            wo_nxt = wsum[13:0];
          end
        end
      end
      CMD_READ: begin
        res0.address = WIN_BASE | {1'b0, ro_r};
        if (n != 4'd0) begin
          res0.bank_select = bank_table_r[{rb_r, 3'b000} +: 8];
          if (split) begin
            // The second segment starts at the base of the next bank.
            two_res           = 1'b1;
            res0.seg_len      = first8;
            res0.last         = 1'b0;
            res1.bank_select  = bank_table_r[{rnext, 3'b000} +: 8];
            res1.seg_len      = in_item.length - first8;
            rb_nxt            = rnext;
            ro_nxt            = {6'd0, in_item.length - first8};
          end else begin
            res0.seg_len = in_item.length;
            if (rsum[14]) begin
              ro_nxt = 14'd0;
              rb_nxt = rnext;
            end else begin
              ro_nxt = rsum[13:0];
            end
          end
        end
      end
      default: begin
      end
    endcase

    res0.fill_level = fill_calc(n, wb_nxt, wo_nxt, rb_nxt, ro_nxt);
    res1.fill_level = res0.fill_level;
  end

  // Output register with a holding stage for the second segment of a read.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    pend_valid_nxt = pend_valid_r;
    pend_item_nxt  = pend_item_r;
    if (out_free) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_item_nxt   = pend_item_r;
        pend_valid_nxt = 1'b0;
      end else if (accept) begin
        out_valid_nxt  = 1'b1;
        out_item_nxt   = res0;
        pend_valid_nxt = two_res;
        pend_item_nxt  = res1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_banks_r  <= 4'd0;
      bank_table_r <= 64'd0;
      wb_r         <= 3'd0;
      wo_r         <= 14'd0;
      rb_r         <= 3'd0;
      ro_r         <= 14'd0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_wr_en && cfg_index == CFG_NUM_BANKS) begin
        num_banks_r <= cfg_data[3:0];
        wb_r        <= 3'd0;
        wo_r        <= 14'd0;
        rb_r        <= 3'd0;
        ro_r        <= 14'd0;
      end else if (accept) begin
        wb_r <= wb_nxt;
        wo_r <= wo_nxt;
        rb_r <= rb_nxt;
        ro_r <= ro_nxt;
      end
      if (cfg_wr_en && cfg_index == CFG_BANK_TABLE) begin
        bank_table_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    pend_item_r <= pend_item_nxt;
  end

endmodule
